// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the tilt filter block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define KALTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kaltf assertion failed");

// Consequent in the cycle after the antecedent.
`define KALTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kaltf assertion failed");

`endif

// ===== sv/kaltf_pkg.sv =====
// Shared types and constants of the Kalman tilt filter block.
// Used by the controller, the datapath, the arithmetic units and the top level.
`default_nettype none

package kaltf_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 28;
    localparam int MUL_DIGIT      = 16;
    localparam int CFG_DATA_W     = 31;
    localparam int CFG_INDEX_W    = 2;
    localparam int PERIOD_W       = 29;
    localparam int COV_ONE        = 1 << FRAC_BITS;

    localparam logic [30:0] ANGLE_NOISE_RST   = 31'd268435;
    localparam logic [30:0] BIAS_NOISE_RST    = 31'd805306;
    localparam logic [30:0] MEASURE_NOISE_RST = 31'd134217728;
    localparam logic [28:0] SAMPLE_PERIOD_RST = 29'd1342177;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ANGLE_NOISE   = 2'd0,
        CFG_BIAS_NOISE    = 2'd1,
        CFG_MEASURE_NOISE = 2'd2,
        CFG_SAMPLE_PERIOD = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        OP_PRED,
        OP_P00,
        OP_P01,
        OP_P11,
        OP_K0,
        OP_K1,
        OP_C00,
        OP_C01,
        OP_C10,
        OP_C11,
        OP_CB,
        OP_CA
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_P00,
        ST_P01,
        ST_P11,
        ST_K0,
        ST_K1,
        ST_C00,
        ST_C01,
        ST_C10,
        ST_C11,
        ST_CB,
        ST_CA,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic start;
        logic zero_gain;
        logic load;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic var_pos;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/kaltf_mul.sv =====
// Shared fractional multiplier: 16 bits of one operand per cycle, then rounding.
// Depends on kaltf_pkg for the digit width and the fraction bits.
`default_nettype none

module kaltf_mul #(
    parameter int WORD_WIDTH = kaltf_pkg::WORD_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    input  wire signed [((WORD_WIDTH > 32) ? WORD_WIDTH : 32):0] op_a,
    input  wire signed [((WORD_WIDTH > 32) ? WORD_WIDTH : 32):0] op_b,
    output logic                              done,
    output logic signed [WORD_WIDTH-1:0]      result
);

    localparam int W    = WORD_WIDTH;
    localparam int MAGW = (W > 32) ? W : 32;
    localparam int DIG  = kaltf_pkg::MUL_DIGIT;
    localparam int NDIG = (MAGW + DIG - 1) / DIG;
    localparam int BW   = NDIG * DIG;
    localparam int PW   = MAGW + BW;
    localparam int F    = kaltf_pkg::FRAC_BITS;
    localparam int RW   = PW + 1 - F;
    localparam int CNTW = $clog2(NDIG + 1);

    localparam logic [PW:0]   HALF = {{(PW + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic [RW-1:0] RMAX = RW'({(W - 1){1'b1}});
    localparam logic [RW-1:0] RLIM = RMAX + RW'(1);
    localparam logic [W-1:0]  MAXW = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  MINW = {1'b1, {(W - 1){1'b0}}};

    logic [MAGW-1:0]     a_mag_reg, a_mag_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                neg_reg, neg_next;
    logic                done_reg, done_next;
    logic [W-1:0]        res_reg, res_next;
    logic [MAGW+DIG-1:0] pp;
    logic [PW:0]         rnd;
    logic [RW-1:0]       r_val;
    logic [MAGW-1:0]     a_in_mag, b_in_mag;

    assign a_in_mag = op_a[MAGW] ? MAGW'(-op_a) : MAGW'(op_a);
    assign b_in_mag = op_b[MAGW] ? MAGW'(-op_b) : MAGW'(op_b);
    assign pp    = {{DIG{1'b0}}, a_mag_reg} * {{MAGW{1'b0}}, b_reg[BW-1 -: DIG]};
    assign rnd   = {1'b0, acc_reg} + HALF;
    assign r_val = rnd[PW:F];

    always_comb
    begin
        a_mag_next = a_mag_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        if (start)
        begin
            a_mag_next = a_in_mag;
            b_next     = BW'(b_in_mag);
            acc_next   = '0;
            cnt_next   = CNTW'(NDIG);
            busy_next  = 1'b1;
            neg_next   = op_a[MAGW] ^ op_b[MAGW];
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            acc_next = (acc_reg << DIG) + PW'(pp);
            b_next   = b_reg << DIG;
            cnt_next = cnt_reg - CNTW'(1);
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (neg_reg)
            begin
                res_next = (r_val > RLIM) ? MINW : -r_val[W-1:0];
            end
            else
            begin
                res_next = (r_val > RMAX) ? MAXW : r_val[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg <= a_mag_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = $signed(res_reg);

endmodule

`default_nettype wire

// ===== sv/kaltf_div.sv =====
// Restoring divider for the gains: one quotient bit per cycle, saturated result.
// Depends on kaltf_pkg for the fraction bits.
`default_nettype none

module kaltf_div #(
    parameter int WORD_WIDTH = kaltf_pkg::WORD_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire signed [WORD_WIDTH-1:0]  num,
    input  wire signed [WORD_WIDTH-1:0]  den,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] result
);

    localparam int W    = WORD_WIDTH;
    localparam int F    = kaltf_pkg::FRAC_BITS;
    localparam int NW   = W + F;
    localparam int CNTW = $clog2(NW + 1);

    localparam logic [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};

    logic [NW-1:0]   dvd_reg, dvd_next;
    logic [W-1:0]    den_reg, den_next;
    logic [W:0]      rem_reg, rem_next;
    logic [W-1:0]    q_reg, q_next;
    logic            ovf_reg, ovf_next;
    logic            neg_reg, neg_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    res_reg, res_next;
    logic [W:0]      rem_sh;
    logic            ge;
    logic [W-1:0]    num_mag;
    logic            big;

    assign num_mag = num[W-1] ? -num : num;
    assign rem_sh  = {rem_reg[W-1:0], dvd_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign big     = ovf_reg | q_reg[W-1];

    always_comb
    begin
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            dvd_next  = {num_mag, {F{1'b0}}};
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            neg_next  = num[W-1];
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            dvd_next = dvd_reg << 1;
            q_next   = {q_reg[W-2:0], ge};
            ovf_next = ovf_reg | q_reg[W-1];
            cnt_next = cnt_reg - CNTW'(1);
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (neg_reg)
            begin
                res_next = big ? MINW : -q_reg;
            end
            else
            begin
                res_next = big ? MAXW : q_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = $signed(res_reg);

endmodule

`default_nettype wire

// ===== sv/kaltf_datapath.sv =====
// Datapath of the tilt filter: settings, filter state, operand selection, write-back.
// Depends on kaltf_pkg, kaltf_mul and kaltf_div.
`default_nettype none

module kaltf_datapath #(
    parameter int WORD_WIDTH = kaltf_pkg::WORD_WIDTH_DEF
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  kaltf_pkg::cmd_t                         cmd,
    output kaltf_pkg::status_t                      status,
    input  wire                                     cfg_we,
    input  wire [kaltf_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire [kaltf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire signed [31:0]                       accel_angle,
    input  wire signed [31:0]                       gyro_rate,
    input  wire                                     out_stall,
    output logic                                    out_valid,
    output logic signed [31:0]                      angle_estimate,
    output logic signed [31:0]                      rate_estimate
);

    localparam int W    = WORD_WIDTH;
    localparam int MAGW = (W > 32) ? W : 32;
    localparam int OPW  = MAGW + 1;
    localparam int EW   = MAGW + 3;
    localparam int CW   = (W > 30) ? W : 30;

    localparam logic signed [EW-1:0] WMAX = {{(EW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [EW-1:0] WMIN = {{(EW - W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam logic signed [EW-1:0] MAX32 = {{(EW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EW-1:0] MIN32 = {{(EW - 31){1'b1}}, {31{1'b0}}};

    function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] y;
        y = (x > WMAX) ? WMAX : ((x < WMIN) ? WMIN : x);
        return y[W-1:0];
    endfunction

    function automatic logic signed [31:0] sat_32(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] y;
        y = (x > MAX32) ? MAX32 : ((x < MIN32) ? MIN32 : x);
        return y[31:0];
    endfunction

    logic [30:0] an_reg, an_next, bn_reg, bn_next, mn_reg, mn_next;
    logic [kaltf_pkg::PERIOD_W-1:0] dt_reg, dt_next;

    logic signed [W-1:0]  angle_reg, angle_next, bias_reg, bias_next;
    logic signed [CW-1:0] paa_reg, paa_next, pab_reg, pab_next;
    logic signed [CW-1:0] pba_reg, pba_next, pbb_reg, pbb_next;
    logic signed [W-1:0]  p00_reg, p00_next, p01_reg, p01_next;
    logic signed [W-1:0]  p10_reg, p10_next, p11_reg, p11_next;
    logic signed [W-1:0]  k0_reg, k0_next, k1_reg, k1_next;
    logic signed [31:0]   acc_reg, acc_next, gyr_reg, gyr_next;
    logic                 ov_reg, ov_next;
    logic signed [31:0]   oa_reg, oa_next, orate_reg, orate_next;

    logic signed [EW-1:0] e_an, e_bn, e_mn;
    logic signed [W-1:0]  var_w, err_w;
    logic signed [OPW-1:0] mul_a, mul_b, e_dt;
    logic signed [W-1:0]  div_num;
    logic                 mul_start, div_start, mul_done, div_done, is_div, unit_done;
    logic signed [W-1:0]  mul_res, div_res;
    logic signed [EW-1:0] e_m;

    assign e_an  = EW'($signed({1'b0, an_reg}));
    assign e_bn  = EW'($signed({1'b0, bn_reg}));
    assign e_mn  = EW'($signed({1'b0, mn_reg}));
    assign e_dt  = OPW'($signed({1'b0, dt_reg}));
    assign e_m   = EW'(mul_res);
    assign var_w = sat_w(e_mn + EW'(p00_reg));
    assign err_w = sat_w(EW'(acc_reg) - EW'(angle_reg));

    assign is_div    = (cmd.op == kaltf_pkg::OP_K0) || (cmd.op == kaltf_pkg::OP_K1);
    assign mul_start = cmd.start && !is_div;
    assign div_start = cmd.start && is_div;
    assign unit_done = mul_done | div_done;

    // Operand selection for the step the controller is running.
    always_comb
    begin
        mul_a   = OPW'(k0_reg);
        mul_b   = e_dt;
        div_num = p00_reg;
        unique case (cmd.op)
            kaltf_pkg::OP_PRED:
            begin
                mul_a = OPW'(sat_w(EW'(gyr_reg) - EW'(bias_reg)));
            end
            kaltf_pkg::OP_P00:
            begin
                mul_a = OPW'(sat_w(e_an - EW'(pab_reg) - EW'(pba_reg)));
            end
            kaltf_pkg::OP_P01: mul_a = OPW'(pbb_reg);
            kaltf_pkg::OP_P11: mul_a = OPW'(e_bn);
            kaltf_pkg::OP_K0:  div_num = p00_reg;
            kaltf_pkg::OP_K1:  div_num = p10_reg;
            kaltf_pkg::OP_C00:
            begin
                mul_a = OPW'(k0_reg);
                mul_b = OPW'(p00_reg);
            end
            kaltf_pkg::OP_C01:
            begin
                mul_a = OPW'(k0_reg);
                mul_b = OPW'(p01_reg);
            end
            kaltf_pkg::OP_C10:
            begin
                mul_a = OPW'(k1_reg);
                mul_b = OPW'(p00_reg);
            end
            kaltf_pkg::OP_C11:
            begin
                mul_a = OPW'(k1_reg);
                mul_b = OPW'(p01_reg);
            end
            kaltf_pkg::OP_CB:
            begin
                mul_a = OPW'(k1_reg);
                mul_b = OPW'(err_w);
            end
            kaltf_pkg::OP_CA:
            begin
                mul_a = OPW'(k0_reg);
                mul_b = OPW'(err_w);
            end
            default:
            begin
                mul_a = OPW'(k0_reg);
            end
        endcase
    end

    // Write-back of unit results, input capture, gain clearing, settings and output register.
    always_comb
    begin
        an_next    = an_reg;
        bn_next    = bn_reg;
        mn_next    = mn_reg;
        dt_next    = dt_reg;
        angle_next = angle_reg;
        bias_next  = bias_reg;
        paa_next   = paa_reg;
        pab_next   = pab_reg;
        pba_next   = pba_reg;
        pbb_next   = pbb_reg;
        p00_next   = p00_reg;
        p01_next   = p01_reg;
        p10_next   = p10_reg;
        p11_next   = p11_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        acc_next   = acc_reg;
        gyr_next   = gyr_reg;
        oa_next    = oa_reg;
        orate_next = orate_reg;
        ov_next    = ov_reg && out_stall;

        if (cfg_we)
        begin
            unique case (kaltf_pkg::cfg_index_t'(cfg_index))
                kaltf_pkg::CFG_ANGLE_NOISE:   an_next = cfg_data;
                kaltf_pkg::CFG_BIAS_NOISE:    bn_next = cfg_data;
                kaltf_pkg::CFG_MEASURE_NOISE: mn_next = cfg_data;
                kaltf_pkg::CFG_SAMPLE_PERIOD: dt_next = cfg_data[kaltf_pkg::PERIOD_W-1:0];
                default:                      an_next = an_reg;
            endcase
        end

        if (cmd.load)
        begin
            acc_next = accel_angle;
            gyr_next = gyro_rate;
        end

        if (cmd.zero_gain)
        begin
            k0_next = '0;
            k1_next = '0;
        end

        if (unit_done)
        begin
            unique case (cmd.op)
                kaltf_pkg::OP_PRED: angle_next = sat_w(EW'(angle_reg) + e_m);
                kaltf_pkg::OP_P00:  p00_next = sat_w(EW'(paa_reg) + e_m);
                kaltf_pkg::OP_P01:
                begin
                    p01_next = sat_w(EW'(pab_reg) - e_m);
                    p10_next = sat_w(EW'(pba_reg) - e_m);
                end
                kaltf_pkg::OP_P11:  p11_next = sat_w(EW'(pbb_reg) + e_m);
                kaltf_pkg::OP_K0:   k0_next = div_res;
                kaltf_pkg::OP_K1:   k1_next = div_res;
                kaltf_pkg::OP_C00:  paa_next = CW'(sat_w(EW'(p00_reg) - e_m));
                kaltf_pkg::OP_C01:  pab_next = CW'(sat_w(EW'(p01_reg) - e_m));
                kaltf_pkg::OP_C10:  pba_next = CW'(sat_w(EW'(p10_reg) - e_m));
                kaltf_pkg::OP_C11:  pbb_next = CW'(sat_w(EW'(p11_reg) - e_m));
                kaltf_pkg::OP_CB:   bias_next = sat_w(EW'(bias_reg) + e_m);
                kaltf_pkg::OP_CA:   angle_next = sat_w(EW'(angle_reg) + e_m);
                default:            angle_next = angle_reg;
            endcase
        end

        if (cmd.emit)
        begin
            ov_next    = 1'b1;
            oa_next    = sat_32(EW'(angle_reg));
            orate_next = sat_32(EW'(gyr_reg) - EW'(bias_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            an_reg    <= kaltf_pkg::ANGLE_NOISE_RST;
            bn_reg    <= kaltf_pkg::BIAS_NOISE_RST;
            mn_reg    <= kaltf_pkg::MEASURE_NOISE_RST;
            dt_reg    <= kaltf_pkg::SAMPLE_PERIOD_RST;
            angle_reg <= '0;
            bias_reg  <= '0;
            paa_reg   <= CW'(kaltf_pkg::COV_ONE);
            pab_reg   <= '0;
            pba_reg   <= '0;
            pbb_reg   <= CW'(kaltf_pkg::COV_ONE);
            ov_reg    <= 1'b0;
        end
        else
        begin
            an_reg    <= an_next;
            bn_reg    <= bn_next;
            mn_reg    <= mn_next;
            dt_reg    <= dt_next;
            angle_reg <= angle_next;
            bias_reg  <= bias_next;
            paa_reg   <= paa_next;
            pab_reg   <= pab_next;
            pba_reg   <= pba_next;
            pbb_reg   <= pbb_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p00_reg   <= p00_next;
        p01_reg   <= p01_next;
        p10_reg   <= p10_next;
        p11_reg   <= p11_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        acc_reg   <= acc_next;
        gyr_reg   <= gyr_next;
        oa_reg    <= oa_next;
        orate_reg <= orate_next;
    end

    kaltf_mul #(
        .WORD_WIDTH(W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    kaltf_div #(
        .WORD_WIDTH(W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (var_w),
        .done   (div_done),
        .result (div_res)
    );

    assign status.done     = unit_done;
    assign status.var_pos  = !var_w[W-1] && (var_w != '0);
    assign status.out_free = !ov_reg || !out_stall;

    assign out_valid      = ov_reg;
    assign angle_estimate = oa_reg;
    assign rate_estimate  = orate_reg;

endmodule

`default_nettype wire

// ===== sv/kaltf_ctrl.sv =====
// Sequencer of the tilt filter: walks predict, gain and correction steps.
// Depends on kaltf_pkg for the state, step and command types.
`default_nettype none

module kaltf_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  kaltf_pkg::status_t status,
    output kaltf_pkg::cmd_t    cmd
);

    kaltf_pkg::state_t state_reg, state_next;
    logic              start_reg, start_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kaltf_pkg::ST_IDLE: if (in_valid) state_next = kaltf_pkg::ST_PRED;
            kaltf_pkg::ST_PRED: if (status.done) state_next = kaltf_pkg::ST_P00;
            kaltf_pkg::ST_P00:  if (status.done) state_next = kaltf_pkg::ST_P01;
            kaltf_pkg::ST_P01:  if (status.done) state_next = kaltf_pkg::ST_P11;
            kaltf_pkg::ST_P11:
            begin
                if (status.done)
                begin
                    state_next = status.var_pos ? kaltf_pkg::ST_K0 : kaltf_pkg::ST_C00;
                end
            end
            kaltf_pkg::ST_K0:   if (status.done) state_next = kaltf_pkg::ST_K1;
            kaltf_pkg::ST_K1:   if (status.done) state_next = kaltf_pkg::ST_C00;
            kaltf_pkg::ST_C00:  if (status.done) state_next = kaltf_pkg::ST_C01;
            kaltf_pkg::ST_C01:  if (status.done) state_next = kaltf_pkg::ST_C10;
            kaltf_pkg::ST_C10:  if (status.done) state_next = kaltf_pkg::ST_C11;
            kaltf_pkg::ST_C11:  if (status.done) state_next = kaltf_pkg::ST_CB;
            kaltf_pkg::ST_CB:   if (status.done) state_next = kaltf_pkg::ST_CA;
            kaltf_pkg::ST_CA:   if (status.done) state_next = kaltf_pkg::ST_EMIT;
            kaltf_pkg::ST_EMIT: if (status.out_free) state_next = kaltf_pkg::ST_IDLE;
            default:            state_next = kaltf_pkg::ST_IDLE;
        endcase
        start_next = (state_next != state_reg) &&
                     (state_next != kaltf_pkg::ST_IDLE) &&
                     (state_next != kaltf_pkg::ST_EMIT);
    end

    always_comb
    begin
        cmd.op        = kaltf_pkg::OP_PRED;
        cmd.start     = start_reg;
        cmd.zero_gain = 1'b0;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        in_stall      = 1'b1;
        unique case (state_reg)
            kaltf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            kaltf_pkg::ST_PRED: cmd.op = kaltf_pkg::OP_PRED;
            kaltf_pkg::ST_P00:  cmd.op = kaltf_pkg::OP_P00;
            kaltf_pkg::ST_P01:  cmd.op = kaltf_pkg::OP_P01;
            kaltf_pkg::ST_P11:
            begin
                cmd.op        = kaltf_pkg::OP_P11;
                cmd.zero_gain = status.done && !status.var_pos;
            end
            kaltf_pkg::ST_K0:   cmd.op = kaltf_pkg::OP_K0;
            kaltf_pkg::ST_K1:   cmd.op = kaltf_pkg::OP_K1;
            kaltf_pkg::ST_C00:  cmd.op = kaltf_pkg::OP_C00;
            kaltf_pkg::ST_C01:  cmd.op = kaltf_pkg::OP_C01;
            kaltf_pkg::ST_C10:  cmd.op = kaltf_pkg::OP_C10;
            kaltf_pkg::ST_C11:  cmd.op = kaltf_pkg::OP_C11;
            kaltf_pkg::ST_CB:   cmd.op = kaltf_pkg::OP_CB;
            kaltf_pkg::ST_CA:   cmd.op = kaltf_pkg::OP_CA;
            kaltf_pkg::ST_EMIT: cmd.emit = status.out_free;
            default:            cmd.op = kaltf_pkg::OP_PRED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kaltf_pkg::ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kalman_tilt_angle_fusion.sv =====
// Top level of the two-state Kalman tilt filter (angle and gyro bias).
// Depends on kaltf_pkg, kaltf_ctrl and kaltf_datapath.
//
// Usage: each input item carries an accelerometer tilt angle and a gyro rate,
// both signed Q16.16, and is taken when in_valid is high and in_stall is low.
// Each item yields exactly one result item on the output channel: the fused
// angle and the gyro rate minus the estimated bias, both signed Q16.16.
// The noise settings and the sample period (Q1.28) are written through the
// cfg_we / cfg_index / cfg_data port, one register per cycle, while idle.
// Sequencing: one item at a time. Between accepting an item and emitting
// its result, the sequencer runs ten fractional multiplies on one shared
// multiplier and two gain divisions on a bit-serial divider; when the
// innovation variance is not positive the divisions are skipped.
// Reset: the settings return to their defaults, angle and bias to zero and
// the covariance to the identity; no result is pending.
// Stall: the result waits in an output register while out_stall is high; a new
// item is taken meanwhile, and the sequencer holds only at the final step.
`default_nettype none

module kalman_tilt_angle_fusion #(
    parameter int WORD_WIDTH = kaltf_pkg::WORD_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [kaltf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [kaltf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire signed [31:0]                 accel_angle,
    input  wire signed [31:0]                 gyro_rate,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic signed [31:0]                angle_estimate,
    output logic signed [31:0]                rate_estimate
);

    // Commands go from the sequencer to the datapath; status flows back.
    kaltf_pkg::cmd_t    cmd;
    kaltf_pkg::status_t status;

    kaltf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the settings, the filter state and both arithmetic
    // units, and owns the output register.
    kaltf_datapath #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .accel_angle    (accel_angle),
        .gyro_rate      (gyro_rate),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .angle_estimate (angle_estimate),
        .rate_estimate  (rate_estimate)
    );

endmodule

`default_nettype wire

// ===== sv/kaltf_checker.sv =====
// Port-level checks of the tilt filter, attached to the top level by bind.
// Depends on assert_macros.svh and on the ports of kalman_tilt_angle_fusion.
`default_nettype none
`include "assert_macros.svh"

module kaltf_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [31:0] angle_estimate,
    input wire [31:0] rate_estimate
);

    // A stalled result stays put.
    `KALTF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(angle_estimate) && $stable(rate_estimate))

    // Once an item is taken, the block is busy on the following cycle.
    `KALTF_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

    // A result never appears in the cycle right after an item is taken.
    `KALTF_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))

    // A new result is produced only while the input side is held off.
    `KALTF_ASSERT_IMP(a_emit_while_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind kalman_tilt_angle_fusion kaltf_checker u_kaltf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .angle_estimate (angle_estimate),
    .rate_estimate  (rate_estimate)
);

`default_nettype wire

// ===== verif/tb_kalman_tilt_angle_fusion.sv =====
// Self-checking testbench for the two-state Kalman tilt filter block.
// Depends on kaltf_pkg and kalman_tilt_angle_fusion; carries its own fixed-point predictor.
`timescale 1ns / 100ps

module tb_kalman_tilt_angle_fusion;

    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 3000000;
    localparam int     ITEMS_PER_SETTING = 262;
    localparam int     HOLD_AFTER  = 400;
    localparam int     HOLD_CYCLES = 2500;

    // Signals at the block's ports.
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [kaltf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [kaltf_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [31:0]    accel_angle;
    logic signed [31:0]    gyro_rate;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [31:0]    angle_estimate;
    logic signed [31:0]    rate_estimate;

    kalman_tilt_angle_fusion dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .accel_angle    (accel_angle),
        .gyro_rate      (gyro_rate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_estimate (angle_estimate),
        .rate_estimate  (rate_estimate)
    );

    // One fused result: what the block should send back for one sample.
    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } fusion_t;

    fusion_t pending_fusion_q[$];

    // The predictor's copy of the settings and of the filter state. The
    // state words hold values already saturated to 32 bits signed, so the
    // wider longint holds every intermediate sum without wrapping.
    longint angle_noise_set, bias_noise_set, measure_noise_set, period_set;
    longint est_angle, est_bias;
    longint cov_aa, cov_ab, cov_ba, cov_bb;

    int  error_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_kalman_tilt_angle_fusion failed");
            $finish;
        end
    end

    function automatic longint clip_word(longint x);
        if (x > WORD_MAX)
            return WORD_MAX;
        if (x < WORD_MIN)
            return WORD_MIN;
        return x;
    endfunction

    // Fractional multiply: round(a*b / 2^28) with halves away from zero.
    // Both operands fit in 32 bits signed, so the magnitude product fits in 64.
    function automatic longint frac_mul(longint a, longint b);
        longint unsigned ma, mb, prod;
        longint v;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        prod = (ma * mb + (64'd1 << (kaltf_pkg::FRAC_BITS - 1))) >> kaltf_pkg::FRAC_BITS;
        v = longint'(prod);
        if ((a < 0) != (b < 0))
            v = -v;
        return clip_word(v);
    endfunction

    // Gain: (num * 2^28) / den truncated toward zero; den is positive here.
    function automatic longint frac_div(longint num, longint den);
        longint unsigned m, q;
        longint v;
        m = (num < 0) ? -num : num;
        q = (m << kaltf_pkg::FRAC_BITS) / longint'(den);
        v = longint'(q);
        if (num < 0)
            v = -v;
        return clip_word(v);
    endfunction

    task automatic reset_filter_model();
        angle_noise_set   = kaltf_pkg::ANGLE_NOISE_RST;
        bias_noise_set    = kaltf_pkg::BIAS_NOISE_RST;
        measure_noise_set = kaltf_pkg::MEASURE_NOISE_RST;
        period_set        = kaltf_pkg::SAMPLE_PERIOD_RST;
        est_angle = 0;
        est_bias  = 0;
        cov_aa    = kaltf_pkg::COV_ONE;
        cov_ab    = 0;
        cov_ba    = 0;
        cov_bb    = kaltf_pkg::COV_ONE;
    endtask

    // One filter step for an accepted sample; queues the fused result.
    task automatic fuse_sample(logic signed [31:0] acc, logic signed [31:0] gyr);
        longint a, g, p00, p01, p10, p11, innov, var_sum, k0, k1;
        fusion_t r;
        a = acc;
        g = gyr;
        k0 = 0;
        k1 = 0;

        // Predict the angle from the bias-corrected rate.
        est_angle = clip_word(est_angle + frac_mul(clip_word(g - est_bias), period_set));

        // Propagate the covariance one period ahead.
        p00 = clip_word(cov_aa
              + frac_mul(clip_word(angle_noise_set - cov_ab - cov_ba), period_set));
        p01 = clip_word(cov_ab - frac_mul(cov_bb, period_set));
        p10 = clip_word(cov_ba - frac_mul(cov_bb, period_set));
        p11 = clip_word(cov_bb + frac_mul(bias_noise_set, period_set));

        // A variance that is not positive leaves the gains at zero, so only
        // the prediction takes effect.
        innov   = clip_word(a - est_angle);
        var_sum = clip_word(measure_noise_set + p00);
        if (var_sum > 0)
        begin
            k0 = frac_div(p00, var_sum);
            k1 = frac_div(p10, var_sum);
        end

        cov_aa = clip_word(p00 - frac_mul(k0, p00));
        cov_ab = clip_word(p01 - frac_mul(k0, p01));
        cov_ba = clip_word(p10 - frac_mul(k1, p00));
        cov_bb = clip_word(p11 - frac_mul(k1, p01));

        est_angle = clip_word(est_angle + frac_mul(k0, innov));
        est_bias  = clip_word(est_bias + frac_mul(k1, innov));

        r.angle = est_angle[31:0];
        r.rate  = 32'(clip_word(g - est_bias));
        pending_fusion_q.push_back(r);
    endtask

    // Offer one sample, idling at random first, and hold it until taken.
    // Entered anywhere between a falling edge and the next rising edge.
    task automatic offer_sample(logic signed [31:0] acc, logic signed [31:0] gyr);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 11)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        accel_angle = acc;
        gyro_rate   = gyr;
        do
            @(posedge clk);
        while (in_stall);
        fuse_sample(acc, gyr);
    endtask

    // Settings change only with no result outstanding; the block is then idle.
    task automatic write_setting(kaltf_pkg::cfg_index_t idx,
                                 logic [kaltf_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_fusion_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            kaltf_pkg::CFG_ANGLE_NOISE:   angle_noise_set   = value;
            kaltf_pkg::CFG_BIAS_NOISE:    bias_noise_set    = value;
            kaltf_pkg::CFG_MEASURE_NOISE: measure_noise_set = value;
            default:                      period_set = value[kaltf_pkg::PERIOD_W-1:0];
        endcase
    endtask

    task automatic write_all_settings(logic [30:0] an, logic [30:0] bn,
                                      logic [30:0] mn, logic [30:0] sp);
        write_setting(kaltf_pkg::CFG_ANGLE_NOISE, an);
        write_setting(kaltf_pkg::CFG_BIAS_NOISE, bn);
        write_setting(kaltf_pkg::CFG_MEASURE_NOISE, mn);
        write_setting(kaltf_pkg::CFG_SAMPLE_PERIOD, sp);
    endtask

    // Random sample: mostly plausible tilt and rate values, with some full
    // range words and some saturation corner values mixed in.
    function automatic logic signed [31:0] pick_word(int plausible_span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $signed($urandom_range(2 * plausible_span)) - plausible_span;
        if (roll < 85)
            return $urandom;
        case ($urandom_range(4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off once a few hundred
    // results have come, so that the output register and then the input
    // side back up while the sender keeps offering samples.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = !quiet && ($urandom_range(99) < 11);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        fusion_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_fusion_q.size() == 0)
            begin
                $error("result with nothing expected: angle %0d rate %0d",
                       angle_estimate, rate_estimate);
                error_count++;
            end
            else
            begin
                want = pending_fusion_q.pop_front();
                if (angle_estimate !== want.angle)
                begin
                    $error("angle_estimate: expected %0d, got %0d", want.angle, angle_estimate);
                    error_count++;
                end
                if (rate_estimate !== want.rate)
                begin
                    $error("rate_estimate: expected %0d, got %0d", want.rate, rate_estimate);
                    error_count++;
                end
            end
        end
    end

    // Directed samples. Only the first row has its result typed in: from
    // reset, a still sensor gives a zero angle and a zero rate.
    typedef struct {
        logic signed [31:0] acc;
        logic signed [31:0] gyr;
        bit                 typed;
        logic signed [31:0] want_angle;
        logic signed [31:0] want_rate;
    } sample_row_t;

    sample_row_t directed_rows[] = '{
        '{32'sd0,          32'sd0,          1, 32'sd0, 32'sd0},
        '{32'sd655360,     32'sd0,          0, 32'sd0, 32'sd0},
        '{32'sd655360,     32'sd65536,      0, 32'sd0, 32'sd0},
        '{-32'sd655360,    -32'sd65536,     0, 32'sd0, 32'sd0},
        '{32'sh7FFF_FFFF,  32'sd0,          0, 32'sd0, 32'sd0},
        '{32'sh8000_0000,  32'sd0,          0, 32'sd0, 32'sd0},
        '{32'sd0,          32'sh7FFF_FFFF,  0, 32'sd0, 32'sd0},
        '{32'sd0,          32'sh8000_0000,  0, 32'sd0, 32'sd0},
        '{32'sh7FFF_FFFF,  32'sh7FFF_FFFF,  0, 32'sd0, 32'sd0},
        '{32'sh8000_0000,  32'sh8000_0000,  0, 32'sd0, 32'sd0},
        '{32'sh7FFF_FFFF,  32'sh8000_0000,  0, 32'sd0, 32'sd0},
        '{-32'sd1,         32'sd1,          0, 32'sd0, 32'sd0},
        '{32'sd1,          -32'sd1,         0, 32'sd0, 32'sd0},
        '{32'sh5555_5555,  32'shAAAA_AAAA,  0, 32'sd0, 32'sd0},
        '{32'shAAAA_AAAA,  32'sh5555_5555,  0, 32'sd0, 32'sd0},
        '{32'sd0,          32'sd0,          0, 32'sd0, 32'sd0}
    };

    // Main sequence: reset, directed rows, then random samples under a
    // series of settings that includes both extremes of every noise register,
    // a zero measurement noise and a period above one second.
    initial
    begin
        int phase;
        int n;
        quiet        = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = kaltf_pkg::CFG_ANGLE_NOISE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        accel_angle  = '0;
        gyro_rate    = '0;
        reset_filter_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            offer_sample(directed_rows[i].acc, directed_rows[i].gyr);
            if (directed_rows[i].typed)
            begin
                pending_fusion_q[$].angle = directed_rows[i].want_angle;
                pending_fusion_q[$].rate  = directed_rows[i].want_rate;
            end
        end

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: ; // keep the reset defaults
                1: write_all_settings(31'd0, 31'd0, 31'd1, 31'd1);
                2: write_all_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                      31'd268435456);
                3: write_all_settings(31'd268435, 31'd805306, 31'd0, 31'h1FFF_FFFF);
                4: write_all_settings(31'($urandom), 31'($urandom), 31'($urandom),
                                      31'($urandom));
                5: write_all_settings(31'd2684354, 31'd8053063, 31'd26843546,
                                      31'd2684355);
                default: write_all_settings(kaltf_pkg::ANGLE_NOISE_RST,
                                            kaltf_pkg::BIAS_NOISE_RST,
                                            kaltf_pkg::MEASURE_NOISE_RST,
                                            31'(kaltf_pkg::SAMPLE_PERIOD_RST));
            endcase
            // Phase five runs with no idling on either side.
            quiet = (phase == 5);
            for (n = 0; n < ITEMS_PER_SETTING; n++)
                offer_sample(pick_word(90 * 65536), pick_word(500 * 65536));
            @(negedge clk);
            in_valid = 1'b0;
        end
        quiet = 0;

        while (pending_fusion_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (error_count == 0)
            $display("tb_kalman_tilt_angle_fusion passed");
        else
            $display("tb_kalman_tilt_angle_fusion failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/kaltf_pkg.sv
sv/kaltf_mul.sv
sv/kaltf_div.sv
sv/kaltf_datapath.sv
sv/kaltf_ctrl.sv
sv/kalman_tilt_angle_fusion.sv
sv/kaltf_checker.sv
verif/tb_kalman_tilt_angle_fusion.sv
